/* design/dps_pkg.sv */
package dps_pkg;

   localparam int DelimLenDefault = 4;
   localparam int DelimLenMax = 8;
   localparam int QueueDepthDefault = 4;
   localparam logic [7:0] DelimResetValue = 8'hFE;

   localparam int CntWidth = $clog2(DelimLenMax);

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic RegDelimiter = 1'b0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_start;
      logic       buffer_end;
   } dps_in_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       last_of_run;
   } dps_out_type;

   typedef struct packed {
      logic [7:0]          delim_value;
      logic [7:0]          data;
      logic [CntWidth-1:0] num_delims;
      logic                emit_byte;
      logic                emit_end;
   } dps_cmd_type;

endpackage

/* design/dps_front.sv */
module dps_front #(
   parameter int DelimLen = dps_pkg::DelimLenDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dps_pkg::dps_in_type   req_data,
   input  logic [7:0]            delimiter,
   input  logic                  queue_full,
   output logic                  push,
   output dps_pkg::dps_cmd_type  push_cmd
);
   import dps_pkg::*;

   localparam int PendWidth = $clog2(DelimLen);

   logic [PendWidth-1:0] pending_ff, pending_in;
   logic                 has_data_ff, has_data_in;
   logic                 accept;
   logic [PendWidth:0]   pend_plus;
   logic                 run_full;
   logic [PendWidth-1:0] run_pend;
   logic                 run_has;
   logic                 flush_has;

   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      pend_plus = {1'b0, pending_ff} + 1'b1;
      run_full = (pend_plus == (PendWidth + 1)'(DelimLen));
      run_pend = run_full ? '0 : pend_plus[PendWidth-1:0];
      run_has = run_full ? 1'b0 : has_data_ff;
      flush_has = run_has || (run_pend != '0);

      push_cmd.delim_value = delimiter;
      push_cmd.data = req_data.data_byte;
      push_cmd.num_delims = '0;
      push_cmd.emit_byte = 1'b0;
      push_cmd.emit_end = 1'b0;
      pending_in = pending_ff;
      has_data_in = has_data_ff;

      if (req_data.buffer_start) begin
         pending_in = '0;
         has_data_in = 1'b0;
      end else if (req_data.data_byte == delimiter) begin
         if (req_data.buffer_end) begin
            push_cmd.num_delims = CntWidth'(run_pend);
            push_cmd.emit_end = (run_full && has_data_ff) || flush_has;
            pending_in = '0;
            has_data_in = 1'b0;
         end else begin
            push_cmd.emit_end = run_full && has_data_ff;
            pending_in = run_pend;
            has_data_in = run_has;
         end
      end else begin
         push_cmd.num_delims = CntWidth'(pending_ff);
         push_cmd.emit_byte = 1'b1;
         push_cmd.emit_end = req_data.buffer_end;
         pending_in = '0;
         has_data_in = !req_data.buffer_end;
      end

      push = accept && ((push_cmd.num_delims != '0) || push_cmd.emit_byte ||
                        push_cmd.emit_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         has_data_ff <= 1'b0;
      end else if (accept) begin
         pending_ff <= pending_in;
         has_data_ff <= has_data_in;
      end
   end

endmodule

/* design/dps_queue.sv */
module dps_queue #(
   parameter int Depth = dps_pkg::QueueDepthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dps_pkg::dps_cmd_type  push_cmd,
   input  logic                  pop,
   output dps_pkg::dps_cmd_type  head_cmd,
   output logic                  empty,
   output logic                  full
);
   import dps_pkg::*;

   localparam int PtrWidth = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   dps_cmd_type           entry_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full = (count_ff == CountWidth'(Depth));
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* design/dps_back.sv */
module dps_back (
   input  logic                  clock,
   input  logic                  reset,
   input  dps_pkg::dps_cmd_type  head_cmd,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dps_pkg::dps_out_type  rsp_data
);
   import dps_pkg::*;

   logic [CntWidth-1:0] sent_ff, sent_in;
   logic                byte_done_ff, byte_done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dps_out_type         rsp_data_ff, rsp_data_in;
   logic                load;
   logic                delim_phase;
   logic                byte_phase;
   logic [CntWidth:0]   sent_next;
   logic                last;

   assign load = !empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      sent_next = {1'b0, sent_ff} + 1'b1;
      delim_phase = (sent_ff < head_cmd.num_delims);
      byte_phase = !delim_phase && head_cmd.emit_byte && !byte_done_ff;

      if (delim_phase) begin
         last = (sent_next == {1'b0, head_cmd.num_delims}) && !head_cmd.emit_byte &&
                !head_cmd.emit_end;
         rsp_data_in = '{out_byte: head_cmd.delim_value, packet_end: 1'b0,
                         last_of_run: last};
      end else if (byte_phase) begin
         last = !head_cmd.emit_end;
         rsp_data_in = '{out_byte: head_cmd.data, packet_end: 1'b0, last_of_run: last};
      end else begin
         last = 1'b1;
         rsp_data_in = '{out_byte: 8'h00, packet_end: 1'b1, last_of_run: 1'b1};
      end

      pop = load && last;
      sent_in = sent_ff;
      byte_done_in = byte_done_ff;
      if (pop) begin
         sent_in = '0;
         byte_done_in = 1'b0;
      end else if (load) begin
         if (delim_phase) begin
            sent_in = sent_next[CntWidth-1:0];
         end else begin
            byte_done_in = 1'b1;
         end
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= '0;
         byte_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff <= sent_in;
         byte_done_ff <= byte_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

/* design/delimiter_packet_splitter.sv */
// The first result of a word is registered in the command queue and then in the output register.
// A word that yields n results keeps the output stage busy until all n are sent.
// Words yielding at most one result are taken back to back, one per cycle, while the queue is not full.
// A four-entry command queue lets input bursts run ahead of longer outputs.
// Synchronous reset clears the run state and the queue and sets the
// delimiter to 0xFE.
module delimiter_packet_splitter #(
   parameter int DelimLen = dps_pkg::DelimLenDefault,
   parameter int QueueDepth = dps_pkg::QueueDepthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  dps_pkg::dps_in_type                req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dps_pkg::dps_out_type               rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dps_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [dps_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [dps_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import dps_pkg::*;

   logic [7:0]  delimiter_ff;
   logic        csr_write;
   logic        push;
   logic        pop;
   logic        queue_empty;
   logic        queue_full;
   dps_cmd_type push_cmd;
   dps_cmd_type head_cmd;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[CsrAddrWidth-1] == RegDelimiter);

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= DelimResetValue;
      end else if (csr_write) begin
         delimiter_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CsrAddrWidth-1] == RegDelimiter) begin
         csr_prdata = {{(CsrDataWidth - 8){1'b0}}, delimiter_ff};
      end
   end

   dps_front #(
      .DelimLen(DelimLen)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .delimiter (delimiter_ff),
      .queue_full(queue_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   dps_queue #(
      .Depth(QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .pop     (pop),
      .head_cmd(head_cmd),
      .empty   (queue_empty),
      .full    (queue_full)
   );

   dps_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

/* design/dps_checker.sv */
module dps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input dps_pkg::dps_out_type               rsp_data,
   input logic                               csr_psel,
   input logic                               csr_penable,
   input logic                               csr_pwrite,
   input logic [dps_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input logic [dps_pkg::CsrDataWidth-1:0]   csr_pwdata,
   input logic [dps_pkg::CsrDataWidth-1:0]   csr_prdata,
   input logic                               csr_pready
);
   import dps_pkg::*;

   // A packet end marker never carries a data byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_end |-> rsp_data.out_byte == 8'h00 &&
                                          rsp_data.last_of_run)
      else $error("packet end carries data or is not last");

   // A stalled word must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled word changed");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("word offered right after reset");

   // A delimiter write reads back on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready &&
      csr_paddr[CsrAddrWidth-1] == RegDelimiter ##1
      csr_paddr[CsrAddrWidth-1] == RegDelimiter |->
      csr_prdata == {{(CsrDataWidth - 8){1'b0}}, $past(csr_pwdata[7:0])})
      else $error("delimiter register readback mismatch");

endmodule

bind delimiter_packet_splitter dps_checker u_dps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data),
   .csr_psel   (csr_psel),
   .csr_penable(csr_penable),
   .csr_pwrite (csr_pwrite),
   .csr_paddr  (csr_paddr),
   .csr_pwdata (csr_pwdata),
   .csr_prdata (csr_prdata),
   .csr_pready (csr_pready)
);
